>>> rtl/core/aes_block_cipher_top_macros.svh
// Assertion macros used by the cipher checker.
`ifndef AES_BLOCK_CIPHER_TOP_MACROS_SVH
`define AES_BLOCK_CIPHER_TOP_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define AES_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define AES_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/aes_pkg.sv
// Shared types, constants and byte functions of the AES cipher.
package aes_pkg;

  localparam int MAX_KEY_WORDS = 60;
  localparam int EIDX_W        = $clog2(MAX_KEY_WORDS);
  localparam int BANK_DEPTH    = 1 << $clog2(MAX_KEY_WORDS / 4);
  localparam int BANK_AW       = $clog2(BANK_DEPTH);
  localparam int CFG_IDX_W     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_SIZE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECRYPT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD3 = 3'd5;

  typedef logic [255:0][7:0] sbox_t;

  typedef struct packed {
    logic               load;
    logic               exp_start;
    logic               exp_step;
    logic               exp_done;
    logic               exp_init;
    logic               exp_mod0;
    logic               exp_mod4;
    logic [EIDX_W-1:0]  exp_idx;
    logic               add0;
    logic               round;
    logic               last;
    logic [BANK_AW-1:0] kaddr;
  } aes_cmd_t;

  typedef struct packed {
    logic       pend;
    logic       dec;
    logic [1:0] sz;
  } aes_sts_t;

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) p = p ^ x;
      x = xt(x);
    end
    return p;
  endfunction

  function automatic logic [7:0] gf_inv(input logic [7:0] a);
    logic [7:0] r;
    r = 8'h01;
    for (int k = 0; k < 254; k++) r = gf_mul(r, a);
    return r;
  endfunction

  function automatic sbox_t gen_sbox();
    sbox_t      t;
    logic [7:0] b;
    for (int i = 0; i < 256; i++) begin
      b = gf_inv(8'(i));
      t[i] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]} ^
             {b[3:0], b[7:4]} ^ 8'h63;
    end
    return t;
  endfunction

  function automatic sbox_t gen_inv_sbox(input sbox_t s);
    sbox_t t;
    for (int i = 0; i < 256; i++) t[s[i]] = 8'(i);
    return t;
  endfunction

  localparam sbox_t SBOX     = gen_sbox();
  localparam sbox_t INV_SBOX = gen_inv_sbox(SBOX);

  function automatic logic [3:0] nk_of(input logic [1:0] sz);
    return 4'd4 + {1'b0, sz, 1'b0};
  endfunction

  function automatic logic [3:0] nr_of(input logic [1:0] sz);
    return 4'd10 + {1'b0, sz, 1'b0};
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w, input logic inv);
    logic [31:0] r;
    for (int k = 0; k < 4; k++)
      r[8*k +: 8] = inv ? INV_SBOX[w[8*k +: 8]] : SBOX[w[8*k +: 8]];
    return r;
  endfunction

  function automatic logic [127:0] subst_state(input logic [127:0] s, input logic inv);
    logic [127:0] r;
    for (int c = 0; c < 4; c++) r[32*c +: 32] = sub_word(s[32*c +: 32], inv);
    return r;
  endfunction

  function automatic logic [127:0] rotate_rows(input logic [127:0] s, input logic inv);
    logic [127:0] r;
    int           src;
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) begin
        src = inv ? (c + 4 - w) % 4 : (c + w) % 4;
        r[127 - 32*c - 8*w -: 8] = s[127 - 32*src - 8*w -: 8];
      end
    end
    return r;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] s, input logic inv);
    logic [127:0] r;
    logic [7:0]   a [4];
    logic [7:0]   x2 [4];
    logic [7:0]   x4 [4];
    logic [7:0]   x8 [4];
    logic [7:0]   v;
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) begin
        a[w]  = s[127 - 32*c - 8*w -: 8];
        x2[w] = xt(a[w]);
        x4[w] = xt(x2[w]);
        x8[w] = xt(x4[w]);
      end
      for (int w = 0; w < 4; w++) begin
        if (!inv) begin
          v = x2[w] ^ x2[(w+1)%4] ^ a[(w+1)%4] ^ a[(w+2)%4] ^ a[(w+3)%4];
        end else begin
          v = (x8[w] ^ x4[w] ^ x2[w]) ^
              (x8[(w+1)%4] ^ x2[(w+1)%4] ^ a[(w+1)%4]) ^
              (x8[(w+2)%4] ^ x4[(w+2)%4] ^ a[(w+2)%4]) ^
              (x8[(w+3)%4] ^ a[(w+3)%4]);
        end
        r[127 - 32*c - 8*w -: 8] = v;
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/core/aes_ram.sv
// Generic single-write, registered-read RAM.
module aes_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/aes_ctrl.sv
// Sequencer for key expansion and the round loop.
module aes_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  input  aes_pkg::aes_sts_t sts,
  output aes_pkg::aes_cmd_t cmd
);
  import aes_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXPAND = 3'd1;
  localparam logic [2:0] ST_KEY0   = 3'd2;
  localparam logic [2:0] ST_ADD0   = 3'd3;
  localparam logic [2:0] ST_ROUND  = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0]         state, state_next;
  logic [EIDX_W-1:0]  eidx, eidx_next;
  logic [2:0]         emod, emod_next;
  logic [BANK_AW-1:0] kidx, kidx_next;
  logic [3:0]         rem, rem_next;
  logic [3:0]         nk, nr;
  logic [EIDX_W-1:0]  total;
  logic [BANK_AW-1:0] first, kstep;

  assign nk    = nk_of(sts.sz);
  assign nr    = nr_of(sts.sz);
  assign total = EIDX_W'({nr, 2'b00} + 6'd4);
  assign first = sts.dec ? BANK_AW'(nr) : '0;
  assign kstep = sts.dec ? kidx - 1'b1 : kidx + 1'b1;
  assign busy  = (state != ST_IDLE);
  assign done  = (state == ST_DONE);

  always_comb begin
    state_next   = state;
    eidx_next    = eidx;
    emod_next    = emod;
    kidx_next    = kidx;
    rem_next     = rem;
    cmd          = '0;
    cmd.exp_idx  = eidx;
    cmd.kaddr    = kidx;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (sts.pend) begin
            state_next    = ST_EXPAND;
            eidx_next     = '0;
            emod_next     = '0;
            cmd.exp_start = 1'b1;
          end else begin
            state_next = ST_KEY0;
            kidx_next  = first;
          end
        end
      end
      ST_EXPAND: begin
        cmd.exp_step = 1'b1;
        cmd.exp_init = ({2'b00, nk} > eidx);
        cmd.exp_mod0 = (emod == 3'd0);
        cmd.exp_mod4 = (emod == 3'd4);
        eidx_next    = eidx + 1'b1;
        emod_next    = ({1'b0, emod} == nk - 4'd1) ? 3'd0 : emod + 3'd1;
        if (eidx == total - 1'b1) begin
          cmd.exp_done = 1'b1;
          state_next   = ST_KEY0;
          kidx_next    = first;
        end
      end
      ST_KEY0: begin
        kidx_next  = kstep;
        rem_next   = nr;
        state_next = ST_ADD0;
      end
      ST_ADD0: begin
        cmd.add0   = 1'b1;
        kidx_next  = kstep;
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        cmd.last  = (rem == 4'd1);
        rem_next  = rem - 4'd1;
        if (rem > 4'd2) kidx_next = kstep;
        if (rem == 4'd1) state_next = ST_DONE;
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    eidx <= eidx_next;
    emod <= emod_next;
    kidx <= kidx_next;
    rem  <= rem_next;
  end

endmodule

>>> rtl/core/aes_dp.sv
// Datapath: configuration registers, key schedule, round-key banks, round unit.
module aes_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [aes_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                    cfg_data,
  input  logic [63:0]                    block_high,
  input  logic [63:0]                    block_low,
  output logic [63:0]                    result_high,
  output logic [63:0]                    result_low,
  input  aes_pkg::aes_cmd_t              cmd,
  output aes_pkg::aes_sts_t              sts
);
  import aes_pkg::*;

  logic [1:0]   key_size;
  logic         decrypt_mode;
  logic [63:0]  key_word [4];
  logic         pend;
  logic [7:0]   rcon;
  logic [31:0]  win [8];
  logic [31:0]  rd [4];
  logic [127:0] st;
  logic [127:0] rk;
  logic [127:0] enc_t, dec_t, round_out;
  logic [31:0]  kw_half, t, w_old, exp_word;
  logic         cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign sts.pend  = pend;
  assign sts.dec   = decrypt_mode;
  assign sts.sz    = (key_size == 2'd3) ? 2'd2 : key_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_size     <= '0;
      decrypt_mode <= 1'b0;
      pend         <= 1'b1;
      for (int k = 0; k < 4; k++) key_word[k] <= '0;
    end else begin
      if (cmd.exp_done) pend <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_KEY_SIZE: begin
            key_size <= cfg_data[1:0];
            pend     <= 1'b1;
          end
          REG_DECRYPT: decrypt_mode <= cfg_data[0];
          REG_KEY_WORD0, REG_KEY_WORD1, REG_KEY_WORD2, REG_KEY_WORD3: begin
            key_word[2'(cfg_index - REG_KEY_WORD0)] <= cfg_data;
            pend <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // key schedule, one word per cycle
  assign kw_half = cmd.exp_idx[0] ? key_word[cmd.exp_idx[2:1]][31:0]
                                  : key_word[cmd.exp_idx[2:1]][63:32];

  always_comb begin
    unique case (sts.sz)
      2'd0:    w_old = win[3];
      2'd1:    w_old = win[5];
      default: w_old = win[7];
    endcase
    t = win[0];
    if (cmd.exp_mod0) begin
      t = sub_word({win[0][23:0], win[0][31:24]}, 1'b0) ^ {rcon, 24'h0};
    end else if (sts.sz == 2'd2 && cmd.exp_mod4) begin
      t = sub_word(win[0], 1'b0);
    end
    exp_word = cmd.exp_init ? kw_half : (w_old ^ t);
  end

  always_ff @(posedge clk) begin
    if (cmd.exp_start) begin
      rcon <= 8'h01;
    end else if (cmd.exp_step && !cmd.exp_init && cmd.exp_mod0) begin
      rcon <= xt(rcon);
    end
    if (cmd.exp_step) begin
      win[0] <= exp_word;
      for (int k = 1; k < 8; k++) win[k] <= win[k-1];
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    aes_ram #(.WIDTH(32), .DEPTH(BANK_DEPTH)) u_ram (
      .clk   (clk),
      .we    (cmd.exp_step && (cmd.exp_idx[1:0] == 2'(b))),
      .waddr (BANK_AW'(cmd.exp_idx[EIDX_W-1:2])),
      .wdata (exp_word),
      .raddr (cmd.kaddr),
      .rdata (rd[b])
    );
  end

  // round unit
  assign rk    = {rd[0], rd[1], rd[2], rd[3]};
  assign enc_t = rotate_rows(subst_state(st, 1'b0), 1'b0);
  assign dec_t = subst_state(rotate_rows(st, 1'b1), 1'b1) ^ rk;

  always_comb begin
    if (!decrypt_mode) begin
      round_out = (cmd.last ? enc_t : mix_cols(enc_t, 1'b0)) ^ rk;
    end else begin
      round_out = cmd.last ? dec_t : mix_cols(dec_t, 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.load) begin
      st <= {block_high, block_low};
    end else if (cmd.add0) begin
      st <= st ^ rk;
    end else if (cmd.round) begin
      st <= round_out;
    end
  end

  assign result_high = st[127:64];
  assign result_low  = st[63:0];

endmodule

>>> rtl/core/aes_block_cipher_top.sv
// Top level of the AES-128/192/256 ECB block cipher.
//
//   channel   handshake                 payload
//   ------    ------------------------  ---------------------------------
//   block     start, busy               block_high, block_low
//   result    done (one-cycle strobe)   result_high, result_low
//   config    cfg_valid, cfg_ready      cfg_index, cfg_data
//
// Done follows the key-read, initial add-key and round states, one round per cycle
// through one round unit; a new block is taken only while busy is low.
// After reset or a key or key-size write, the first block adds key expansion of 44,
// 52 or 60 schedule words, one schedule word per cycle.
// Reset is synchronous; the round-key banks need no clearing.
// Results cannot be stalled: done is high for exactly one cycle.
module aes_block_cipher_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [63:0]                   block_high,
  input  logic [63:0]                   block_low,
  output logic                          done,
  output logic [63:0]                   result_high,
  output logic [63:0]                   result_low,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [aes_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data
);
  import aes_pkg::*;

  aes_cmd_t cmd;
  aes_sts_t sts;

  aes_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .sts   (sts),
    .cmd   (cmd)
  );

  aes_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .block_high  (block_high),
    .block_low   (block_low),
    .result_high (result_high),
    .result_low  (result_low),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

>>> rtl/core/aes_chk.sv
// Port-level checker for the cipher top, bound to it.
`include "aes_block_cipher_top_macros.svh"

module aes_chk (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  `AES_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted word did not raise busy")
  `AES_ASSERT_NOW(a_done_busy, done, busy, "done seen while idle")
  `AES_ASSERT_NEXT(a_done_pulse, done, !done, "done held longer than one cycle")
  `AES_ASSERT_NEXT(a_done_idle, done, !busy, "busy still high after done")

endmodule

bind aes_block_cipher_top aes_chk u_chk (.*);

>>> tb/sv/aes_block_cipher_top_test.sv
// Self-checking test of the AES ECB block cipher top level against an in-bench cipher model.
`timescale 1ns / 100ps

module aes_block_cipher_top_test;
  import aes_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int NUM_RANDOM = 700;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [63:0]          block_high;
  logic [63:0]          block_low;
  logic                 done;
  logic [63:0]          result_high;
  logic [63:0]          result_low;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0]          cfg_data;

  aes_block_cipher_top u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .block_high(block_high), .block_low(block_low),
    .done(done), .result_high(result_high), .result_low(result_low),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  logic [1:0]   cur_key_size;
  logic         cur_decrypt;
  logic [63:0]  cur_key [4];
  logic [31:0]  sched [60];
  logic         sched_stale;
  int           sched_rounds;
  logic [127:0] pending_blocks [$];
  int           mismatches;
  int           idle_cycles;
  logic [7:0]   fwd_sbox [256];
  logic [7:0]   inv_sbox_t [256];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] gmul8(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    end
    return p;
  endfunction

  task automatic build_sboxes();
    logic [7:0] inv;
    logic [7:0] b;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h01;
      for (int k = 0; k < 254; k++) inv = gmul8(inv, 8'(x));
      b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]} ^
          {inv[3:0], inv[7:4]} ^ 8'h63;
      fwd_sbox[x] = b;
      inv_sbox_t[b] = 8'(x);
    end
  endtask

  function automatic logic [31:0] subst32(input logic [31:0] w, input logic inverse);
    logic [31:0] r;
    for (int k = 0; k < 4; k++)
      r[8*k +: 8] = inverse ? inv_sbox_t[w[8*k +: 8]] : fwd_sbox[w[8*k +: 8]];
    return r;
  endfunction

  task automatic expand_schedule();
    int          sz;
    int          nk;
    int          total;
    logic [31:0] t;
    logic [7:0]  rc;
    sz = (cur_key_size > 2) ? 2 : int'(cur_key_size);
    sched_rounds = 10 + 2 * sz;
    nk = 4 + 2 * sz;
    total = 4 * (sched_rounds + 1);
    for (int i = 0; i < nk; i++)
      sched[i] = i[0] ? cur_key[i / 2][31:0] : cur_key[i / 2][63:32];
    for (int i = nk; i < total; i++) begin
      t = sched[i - 1];
      if (i % nk == 0) begin
        rc = 8'h01;
        for (int k = 1; k < i / nk; k++) rc = gmul8(rc, 8'h02);
        t = subst32({t[23:0], t[31:24]}, 1'b0) ^ {rc, 24'h0};
      end else if (nk > 6 && i % nk == 4) begin
        t = subst32(t, 1'b0);
      end
      sched[i] = sched[i - nk] ^ t;
    end
    sched_stale = 1'b0;
  endtask

  function automatic logic [31:0] col_mix(input logic [31:0] w, input logic inverse);
    logic [7:0]  a [4];
    logic [7:0]  m [4];
    logic [7:0]  v;
    logic [31:0] r;
    if (inverse) m = '{8'h0E, 8'h0B, 8'h0D, 8'h09};
    else m = '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int i = 0; i < 4; i++) a[i] = w[31 - 8*i -: 8];
    for (int i = 0; i < 4; i++) begin
      v = 8'h00;
      for (int k = 0; k < 4; k++) v ^= gmul8(m[k], a[(i + k) % 4]);
      r[31 - 8*i -: 8] = v;
    end
    return r;
  endfunction

  function automatic logic [127:0] cipher_block(input logic [127:0] blk);
    logic [31:0] s [4];
    logic [31:0] t [4];
    int          d1;
    int          d3;
    for (int c = 0; c < 4; c++) s[c] = blk[127 - 32*c -: 32];
    d1 = cur_decrypt ? 3 : 1;
    d3 = cur_decrypt ? 1 : 3;
    for (int step = 0; step <= sched_rounds; step++) begin
      int r;
      r = cur_decrypt ? sched_rounds - step : step;
      if (step > 0) begin
        for (int c = 0; c < 4; c++)
          t[c] = {s[c][31:24], s[(c + d1) % 4][23:16], s[(c + 2) % 4][15:8],
                  s[(c + d3) % 4][7:0]};
        for (int c = 0; c < 4; c++) s[c] = subst32(t[c], cur_decrypt);
        if (!cur_decrypt && r < sched_rounds)
          for (int c = 0; c < 4; c++) s[c] = col_mix(s[c], 1'b0);
      end
      for (int c = 0; c < 4; c++) s[c] ^= sched[4*r + c];
      if (cur_decrypt && step > 0 && r > 0)
        for (int c = 0; c < 4; c++) s[c] = col_mix(s[c], 1'b1);
    end
    return {s[0], s[1], s[2], s[3]};
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("aes_block_cipher_top_test: errors");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    logic [127:0] want;
    if (!rst && done) begin
      if (pending_blocks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h %h", result_high, result_low);
      end else begin
        want = pending_blocks.pop_front();
        if (result_high !== want[127:64] || result_low !== want[63:0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %h %h, got %h %h",
                     want[127:64], want[63:0], result_high, result_low);
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_KEY_SIZE: begin
        cur_key_size = val[1:0];
        sched_stale = 1'b1;
      end
      REG_DECRYPT: cur_decrypt = val[0];
      REG_KEY_WORD0, REG_KEY_WORD1, REG_KEY_WORD2, REG_KEY_WORD3: begin
        cur_key[2'(idx - REG_KEY_WORD0)] = val;
        sched_stale = 1'b1;
      end
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
    int gap;
    gap = $urandom_range(0, 6);
    repeat (gap) @(posedge clk);
    start <= 1'b1;
    block_high <= hi;
    block_low <= lo;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (sched_stale) expand_schedule();
    pending_blocks.insert(pending_blocks.size(), cipher_block({hi, lo}));
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic set_key(input logic [1:0] sz, input logic dec, input logic [63:0] k0,
                         input logic [63:0] k1, input logic [63:0] k2, input logic [63:0] k3);
    drain();
    write_reg(REG_KEY_SIZE, {62'h0, sz});
    write_reg(REG_DECRYPT, {63'h0, dec});
    write_reg(REG_KEY_WORD0, k0);
    write_reg(REG_KEY_WORD1, k1);
    write_reg(REG_KEY_WORD2, k2);
    write_reg(REG_KEY_WORD3, k3);
  endtask

  task automatic test_reset_key();
    send_block(64'h0, 64'h0);
    send_block('1, '1);
  endtask

  task automatic test_known_vectors();
    set_key(2'd0, 1'b0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h0, 64'h0);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    set_key(2'd1, 1'b0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
            64'h1011121314151617, 64'h0);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    set_key(2'd2, 1'b1, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
            64'h1011121314151617, 64'h18191a1b1c1d1e1f);
    send_block(64'h8ea2b7ca516745bf, 64'heafc49904b496089);
  endtask

  task automatic test_extremes();
    set_key(2'd3, 1'b0, '1, '1, '1, '1);
    send_block(64'h0, 64'h0);
    send_block('1, '1);
    send_block(64'h8000000000000000, 64'h1);
    drain();
    write_reg(REG_DECRYPT, 64'h1);
    send_block('1, 64'h0);
    drain();
    write_reg(3'd6, 64'h3);
    write_reg(3'd7, '1);
    send_block(64'h0, '1);
    set_key(2'd0, 1'b1, 64'h0, 64'h0, 64'h0, 64'h0);
    send_block(64'h0, 64'h0);
    send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
  endtask

  task automatic test_random_blocks();
    for (int phase = 0; phase < 14; phase++) begin
      set_key(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
              rand64(), rand64(), rand64(), rand64());
      for (int n = 0; n < NUM_RANDOM / 14; n++) begin
        send_block(rand64(), rand64());
        if (n == 20) begin
          drain();
          write_reg(REG_DECRYPT, {63'h0, 1'($urandom_range(0, 1))});
        end
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    block_high = '0;
    block_low = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    cur_key_size = 2'd0;
    cur_decrypt = 1'b0;
    for (int i = 0; i < 4; i++) cur_key[i] = '0;
    sched_stale = 1'b1;
    sched_rounds = 10;
    build_sboxes();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_key();
    test_known_vectors();
    test_extremes();
    test_random_blocks();
    drain();
    if (mismatches == 0) $display("aes_block_cipher_top_test: clean");
    else $display("aes_block_cipher_top_test: errors");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/aes_pkg.sv
rtl/core/aes_ram.sv
rtl/core/aes_ctrl.sv
rtl/core/aes_dp.sv
rtl/core/aes_block_cipher_top.sv
rtl/core/aes_chk.sv
tb/sv/aes_block_cipher_top_test.sv
